// ===== hw/rtl/h2b_pkg.sv =====
// h2b_pkg: types, character codes and the per-character parse step
// for the hex text to bytes converter; no dependencies
package h2b_pkg;

   localparam logic [1:0] PHASE_START = 2'd0;   // awaiting first character
   localparam logic [1:0] PHASE_HELD  = 2'd1;   // leading zero held
   localparam logic [1:0] PHASE_BODY  = 2'd2;   // body of the string

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LC_A   = 8'h61;
   localparam logic [7:0] CHAR_LC_F   = 8'h66;
   localparam logic [7:0] CHAR_UC_A   = 8'h41;
   localparam logic [7:0] CHAR_UC_F   = 8'h46;
   localparam logic [7:0] CHAR_LC_X   = 8'h78;
   localparam logic [7:0] CHAR_UC_X   = 8'h58;
   localparam logic [7:0] CHAR_DASH   = 8'h2d;

   localparam logic [7:0] DASH_RUN_MAX = 8'hff;
   localparam logic [3:0] LETTER_ADJ   = 4'd9;   // 'a'/'A' low nibble 1 maps to 10

   typedef struct packed {
      logic [1:0] phase;
      logic       held_zero;
      logic [3:0] nibble_acc;
      logic       half_full;
      logic [7:0] bytes_done;
      logic [7:0] dash_run;
      logic       failed;
   } parse_state_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic [7:0] byte_index;
      logic       done_res;
      logic       parse_ok;
   } result_type;

   typedef struct packed {
      parse_state_type st;
      logic            emit;
      logic [7:0]      out_byte;
      logic [7:0]      byte_index;
   } feed_type;

   // one character into the packer
   function automatic feed_type feed_char(parse_state_type st, logic [7:0] c,
                                          logic [7:0] limit);
      feed_type   r;
      logic [3:0] v;
      logic       is_hex;
      r.st         = st;
      r.emit       = 1'b0;
      r.out_byte   = '0;
      r.byte_index = st.bytes_done;
      v            = '0;
      is_hex       = 1'b0;
      if (!(st.failed || (st.bytes_done >= limit))) begin
         if (c == CHAR_DASH) begin
            if (st.dash_run != DASH_RUN_MAX) begin
               r.st.dash_run = st.dash_run + 8'd1;
            end
            if (r.st.dash_run >= limit) begin
               r.st.failed = 1'b1;
            end
         end else begin
            if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
               v      = c[3:0];
               is_hex = 1'b1;
            end else if (c inside {[CHAR_LC_A:CHAR_LC_F], [CHAR_UC_A:CHAR_UC_F]}) begin
               v      = c[3:0] + LETTER_ADJ;
               is_hex = 1'b1;
            end
            if (!is_hex) begin
               r.st.failed = 1'b1;
            end else begin
               r.st.dash_run = '0;
               if (st.half_full) begin
                  r.emit          = 1'b1;
                  r.out_byte      = {st.nibble_acc, v};
                  r.st.bytes_done = st.bytes_done + 8'd1;
                  r.st.nibble_acc = '0;
                  r.st.half_full  = 1'b0;
               end else begin
                  r.st.nibble_acc = v;
                  r.st.half_full  = 1'b1;
               end
            end
         end
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/hex_text_to_bytes.sv =====
// hex_text_to_bytes: packs an ascii hex string, one character per transaction,
// into bytes followed by a status; uses h2b_pkg
//
//   channel | dir | handshake                 | payload
//   req     | in  | req_tvalid / req_tready   | tdata text_char, tlast end_of_text
//   rsp     | out | rsp_tvalid / rsp_tready   | tdata out_byte, byte_index, parse_ok;
//           |     |                           | tuser byte_valid, done_res
//   csr     | in  | csr_valid / csr_ready     | csr_data byte_limit
//
// one character per cycle while the queue has room: a character is held in the input
// register, is parsed there and its results (up to two) go to a small output queue
// a character with no room for two results in the queue waits in the input
// register; the queue drains one result per cycle as rsp_tready allows
// reset (synchronous, active high) clears the parse state, the queue and sets
// the byte limit to 4; the csr channel is always ready
module hex_text_to_bytes #(
   parameter int unsigned OUT_DEPTH = 4      // result queue entries, at least 2
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,            // [7:0] text_char
   input  logic        req_tlast,            // end_of_text

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,            // [7:0] out_byte, [15:8] byte_index,
                                             // [16] parse_ok, [23:17] zero
   output logic [1:0]  rsp_tuser,            // [0] byte_valid, [1] done_res

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data              // byte_limit
);

   localparam int unsigned PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(OUT_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(OUT_DEPTH - 2);

   // configuration register
   logic [7:0] byte_limit_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // parse state
   h2b_pkg::parse_state_type state_ff, state_in;

   // result queue
   h2b_pkg::result_type queue_ff [OUT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in, wr_ptr_nx;
   logic [CNT_W-1:0] count_ff, count_in;

   // step outputs
   h2b_pkg::result_type res0, res1;
   logic [1:0]          res_cnt;
   logic                proc_fire;
   logic                pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_limit_ff <= 8'd4;
      end else if (csr_valid) begin
         byte_limit_ff <= csr_data;
      end
   end

   // a character is parsed when there is room for its worst case of two results
   assign proc_fire  = in_valid_ff && (count_ff <= CNT_ROOM);
   assign req_tready = !in_valid_ff || proc_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // parse step for the character in the input register
   always_comb begin
      h2b_pkg::parse_state_type st;
      h2b_pkg::feed_type        f0;
      h2b_pkg::feed_type        f1;
      logic                     emit_a;
      logic [7:0]               byte_a;
      logic [7:0]               idx_a;
      logic                     part_emit;
      h2b_pkg::result_type      r_a;
      h2b_pkg::result_type      r_part;
      h2b_pkg::result_type      r_stat;

      st     = state_ff;
      emit_a = 1'b0;
      byte_a = '0;
      idx_a  = '0;
      f0     = '0;
      f1     = '0;

      case (state_ff.phase)
         h2b_pkg::PHASE_START: begin
            if ((in_char_ff == h2b_pkg::CHAR_ZERO) && !in_last_ff) begin
               st.held_zero = 1'b1;
               st.phase     = h2b_pkg::PHASE_HELD;
            end else begin
               f1       = h2b_pkg::feed_char(st, in_char_ff, byte_limit_ff);
               st       = f1.st;
               st.phase = h2b_pkg::PHASE_BODY;
               emit_a   = f1.emit;
               byte_a   = f1.out_byte;
               idx_a    = f1.byte_index;
            end
         end
         h2b_pkg::PHASE_HELD: begin
            // "0x"/"0X" is a prefix only if more characters follow
            if (((in_char_ff == h2b_pkg::CHAR_LC_X) || (in_char_ff == h2b_pkg::CHAR_UC_X))
                && !in_last_ff) begin
               st.held_zero = 1'b0;
            end else begin
               if (st.held_zero) begin
                  f0 = h2b_pkg::feed_char(st, h2b_pkg::CHAR_ZERO, byte_limit_ff);
                  st = f0.st;
               end
               st.held_zero = 1'b0;
               // the held zero only fills a nibble, so just this feed can emit
               f1     = h2b_pkg::feed_char(st, in_char_ff, byte_limit_ff);
               st     = f1.st;
               emit_a = f1.emit;
               byte_a = f1.out_byte;
               idx_a  = f1.byte_index;
            end
            st.phase = h2b_pkg::PHASE_BODY;
         end
         default: begin
            f1     = h2b_pkg::feed_char(st, in_char_ff, byte_limit_ff);
            st     = f1.st;
            emit_a = f1.emit;
            byte_a = f1.out_byte;
            idx_a  = f1.byte_index;
         end
      endcase

      // end of string: trailing dash check and flush of a lone nibble
      part_emit = 1'b0;
      if (in_last_ff && !st.failed && (st.bytes_done < byte_limit_ff)) begin
         if (st.dash_run != '0) begin
            st.failed = 1'b1;
         end
         part_emit = st.half_full;
      end

      r_a        = '0;
      r_a.byte_valid = 1'b1;
      r_a.out_byte   = byte_a;
      r_a.byte_index = idx_a;

      r_part            = '0;
      r_part.byte_valid = 1'b1;
      r_part.out_byte   = {4'd0, st.nibble_acc};
      r_part.byte_index = st.bytes_done;

      r_stat          = '0;
      r_stat.done_res = 1'b1;
      r_stat.parse_ok = !st.failed;

      // collect results in order; a character yields at most two
      res0    = '0;
      res1    = '0;
      res_cnt = 2'd0;
      if (emit_a) begin
         res0    = r_a;
         res_cnt = 2'd1;
      end
      if (in_last_ff) begin
         if (part_emit) begin
            if (res_cnt == 2'd0) begin
               res0 = r_part;
            end else begin
               res1 = r_part;
            end
            res_cnt = res_cnt + 2'd1;
         end
         if (res_cnt == 2'd0) begin
            res0 = r_stat;
         end else begin
            res1 = r_stat;
         end
         res_cnt = res_cnt + 2'd1;
         st      = '0;
      end

      state_in = proc_fire ? st : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // result queue
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign wr_ptr_nx  = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (proc_fire && (res_cnt == 2'd1)) begin
         wr_ptr_in = wr_ptr_nx;
      end else if (proc_fire && (res_cnt == 2'd2)) begin
         wr_ptr_in = (wr_ptr_nx == PTR_LAST) ? '0 : wr_ptr_nx + PTR_W'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + (proc_fire ? CNT_W'(res_cnt) : '0) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire && (res_cnt != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (proc_fire && (res_cnt == 2'd2)) begin
         queue_ff[wr_ptr_nx] <= res1;
      end
   end

   always_comb begin
      h2b_pkg::result_type head;
      head      = queue_ff[rd_ptr_ff];
      rsp_tdata = {7'd0, head.parse_ok, head.byte_index, head.out_byte};
      rsp_tuser = {head.done_res, head.byte_valid};
   end

endmodule

// ===== verif/tb_hex_text_to_bytes.sv =====
// tb_hex_text_to_bytes: self-checking testbench for the hex text to bytes converter
// predicts byte and status transactions per character in a scoreboard class
// depends on h2b_pkg and hex_text_to_bytes
module tb_hex_text_to_bytes;

   localparam int         WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
   localparam int         SETTLE_CYCLES  = 8;     // quiet time before a csr write and at the end
   localparam logic [7:0] LETTER_BASE    = 8'd10; // value of 'a' / 'A'
   localparam logic [7:0] DASH_SAT       = 8'hff; // dash counter saturates here

   // scoreboard: own copy of the parse state, expected transactions in order
   class byte_packer_model;
      logic [7:0] limit;
      logic [1:0] phase;
      logic       held_zero;
      logic [3:0] nibble_acc;
      logic       half_full;
      logic [7:0] bytes_done;
      logic [7:0] dash_run;
      logic       failed;
      h2b_pkg::result_type pending[$];
      int         errors;

      function new();
         limit  = 8'd4;
         errors = 0;
         clear_string();
      endfunction

      function void clear_string();
         phase      = h2b_pkg::PHASE_START;
         held_zero  = 1'b0;
         nibble_acc = '0;
         half_full  = 1'b0;
         bytes_done = '0;
         dash_run   = '0;
         failed     = 1'b0;
      endfunction

      function void emit(logic bv, logic [7:0] value, logic [7:0] idx, logic done,
                         logic ok);
         h2b_pkg::result_type r;
         r.byte_valid = bv;
         r.out_byte   = value;
         r.byte_index = idx;
         r.done_res   = done;
         r.parse_ok   = ok;
         pending.push_back(r);
      endfunction

      // one character into the nibble packer
      function void pack_char(logic [7:0] c);
         logic [3:0] v;
         if (failed || bytes_done >= limit) return;
         if (c == h2b_pkg::CHAR_DASH) begin
            if (dash_run != DASH_SAT) dash_run++;
            if (dash_run >= limit) failed = 1'b1;
            return;
         end
         if (c >= h2b_pkg::CHAR_ZERO && c <= h2b_pkg::CHAR_NINE) begin
            v = 4'(c - h2b_pkg::CHAR_ZERO);
         end else if (c >= h2b_pkg::CHAR_LC_A && c <= h2b_pkg::CHAR_LC_F) begin
            v = 4'(c - h2b_pkg::CHAR_LC_A + LETTER_BASE);
         end else if (c >= h2b_pkg::CHAR_UC_A && c <= h2b_pkg::CHAR_UC_F) begin
            v = 4'(c - h2b_pkg::CHAR_UC_A + LETTER_BASE);
         end else begin
            failed = 1'b1;
            return;
         end
         dash_run = '0;
         if (half_full) begin
            emit(1'b1, {nibble_acc, v}, bytes_done, 1'b0, 1'b0);
            bytes_done++;
            nibble_acc = '0;
            half_full  = 1'b0;
         end else begin
            nibble_acc = v;
            half_full  = 1'b1;
         end
      endfunction

      // accepted input transaction: prefix handling, packing, end of string
      function void note_char(logic [7:0] c, logic last);
         if (phase == h2b_pkg::PHASE_START) begin
            if (c == h2b_pkg::CHAR_ZERO && !last) begin
               held_zero = 1'b1;
               phase     = h2b_pkg::PHASE_HELD;
            end else begin
               pack_char(c);
               phase = h2b_pkg::PHASE_BODY;
            end
         end else if (phase == h2b_pkg::PHASE_HELD) begin
            // 0x only counts as a prefix when more characters follow
            if ((c == h2b_pkg::CHAR_LC_X || c == h2b_pkg::CHAR_UC_X) && !last) begin
               held_zero = 1'b0;
            end else begin
               if (held_zero) pack_char(h2b_pkg::CHAR_ZERO);
               held_zero = 1'b0;
               pack_char(c);
            end
            phase = h2b_pkg::PHASE_BODY;
         end else begin
            pack_char(c);
         end
         if (last) begin
            if (!failed && bytes_done < limit) begin
               if (dash_run != 0) failed = 1'b1;
               // lone nibble goes out in the low half
               if (half_full) emit(1'b1, {4'd0, nibble_acc}, bytes_done, 1'b0, 1'b0);
            end
            emit(1'b0, 8'd0, 8'd0, 1'b1, !failed);
            clear_string();
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(h2b_pkg::result_type got);
         h2b_pkg::result_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", got));
            return;
         end
         want = pending.pop_front();
         if (got.byte_valid !== want.byte_valid)
            report_mismatch($sformatf("byte_valid %b, want %b", got.byte_valid,
                                      want.byte_valid));
         if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
         if (got.byte_index !== want.byte_index)
            report_mismatch($sformatf("byte_index %0d, want %0d", got.byte_index,
                                      want.byte_index));
         if (got.done_res !== want.done_res)
            report_mismatch($sformatf("done_res %b, want %b", got.done_res, want.done_res));
         if (got.parse_ok !== want.parse_ok)
            report_mismatch($sformatf("parse_ok %b, want %b", got.parse_ok, want.parse_ok));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   byte_packer_model sb = new();
   int send_idle_pct;
   int recv_idle_pct;
   int chars_sent;
   int quiet_cycles;

   hex_text_to_bytes uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver: random back-pressure, changed at the falling edge
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result monitor and watchdog
   always @(posedge clock) begin : monitor
      h2b_pkg::result_type got;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte   = rsp_tdata[7:0];
            got.byte_index = rsp_tdata[15:8];
            got.parse_ok   = rsp_tdata[16];
            got.byte_valid = rsp_tuser[0];
            got.done_res   = rsp_tuser[1];
            sb.check_result(got);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("hex_text_to_bytes regression: fail");
            $finish;
         end
      end
   end

   // one character transaction; valid stays high into the next call unless it idles
   task automatic send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = c;
      req_tlast  = last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_char(c, last);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] random_hex_char();
      case ($urandom_range(2))
         0: return h2b_pkg::CHAR_ZERO + 8'($urandom_range(9));
         1: return h2b_pkg::CHAR_LC_A + 8'($urandom_range(5));
         default: return h2b_pkg::CHAR_UC_A + 8'($urandom_range(5));
      endcase
   endfunction

   // any byte that is neither a hex digit nor a dash
   function automatic logic [7:0] random_bad_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(255));
      end while ((c >= h2b_pkg::CHAR_ZERO && c <= h2b_pkg::CHAR_NINE) ||
                 (c >= h2b_pkg::CHAR_LC_A && c <= h2b_pkg::CHAR_LC_F) ||
                 (c >= h2b_pkg::CHAR_UC_A && c <= h2b_pkg::CHAR_UC_F) ||
                 c == h2b_pkg::CHAR_DASH);
      return c;
   endfunction

   task automatic send_dashes(input int n);
      for (int i = 0; i < n; i++) send_char(h2b_pkg::CHAR_DASH, 1'b0);
   endtask

   // one string: mostly well formed, the rest noise and broken forms
   task automatic send_random_string();
      int kind;
      int n;
      int lim;
      int max_run;
      kind    = $urandom_range(99);
      lim     = sb.limit;
      max_run = (lim > 1) ? ((lim - 1 < 3) ? lim - 1 : 3) : 0;
      if (kind < 72) begin
         if ($urandom_range(2) == 0) begin
            send_char(h2b_pkg::CHAR_ZERO, 1'b0);
            send_char($urandom_range(1) ? h2b_pkg::CHAR_LC_X : h2b_pkg::CHAR_UC_X, 1'b0);
         end
         n = (lim <= 8) ? $urandom_range(1, 2 * lim + 2) : $urandom_range(1, 16);
         if (n < 1) n = 1;
         for (int i = 0; i < n; i++) begin
            send_char(random_hex_char(), i == n - 1);
            // dash runs short of the limit are skipped
            if (i != n - 1 && max_run > 0 && $urandom_range(7) == 0)
               send_dashes($urandom_range(1, max_run));
         end
      end else if (kind < 80) begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) send_char(8'($urandom_range(255)), i == n - 1);
      end else if (kind < 84) begin
         // trailing dash
         send_char(random_hex_char(), 1'b0);
         send_char(h2b_pkg::CHAR_DASH, 1'b1);
      end else if (kind < 88) begin
         // dash run as long as the limit where that is cheap
         send_char(random_hex_char(), 1'b0);
         send_dashes((lim >= 1 && lim <= 8) ? lim : $urandom_range(1, 4));
         send_char(random_hex_char(), 1'b1);
      end else if (kind < 92) begin
         // bare prefix or lone zero
         if ($urandom_range(2) == 0) begin
            send_char(h2b_pkg::CHAR_ZERO, 1'b1);
         end else begin
            send_char(h2b_pkg::CHAR_ZERO, 1'b0);
            send_char($urandom_range(1) ? h2b_pkg::CHAR_LC_X : h2b_pkg::CHAR_UC_X, 1'b1);
         end
      end else if (kind < 96) begin
         // leading zero that is a digit after all
         send_char(h2b_pkg::CHAR_ZERO, 1'b0);
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) send_char(random_hex_char(), i == n - 1);
      end else begin
         // invalid character inside the body
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) send_char(random_hex_char(), 1'b0);
         send_char(random_bad_char(), 1'($urandom_range(1)));
         if (!req_tlast) send_char(random_hex_char(), 1'b1);
      end
   endtask

   task automatic run_random(input int items);
      int target;
      target = chars_sent + items;
      while (chars_sent < target) send_random_string();
   endtask

   // limit written only with nothing in flight
   task automatic write_limit(input int value);
      req_tvalid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = 8'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.limit = 8'(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      chars_sent    = 0;
      send_idle_pct = 8;
      recv_idle_pct = 62;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed strings at the reset limit of 4
      send_text("0x1F");           // prefix dropped
      send_text("0X");             // too short to be a prefix
      send_text("a-B");            // dash skipped, a and B packed into one byte
      send_text("0");              // lone zero
      send_text("9f-");            // trailing dash
      send_text("----");           // dash run as long as the limit
      send_char(8'h00, 1'b1);      // lowest character code
      send_char(8'h35, 1'b0);
      send_char(8'hff, 1'b1);      // highest code, string fails and the lone digit is dropped
      run_random(150);

      write_limit(1);
      send_text("1A7");            // limit reached, rest ignored
      send_text("00");
      run_random(150);

      // receiver now mostly ready, sender slow
      send_idle_pct = 62;
      recv_idle_pct = 8;
      write_limit(255);
      for (int i = 0; i < 514; i++) send_char(random_hex_char(), i == 513);
      run_random(100);
      write_limit(2);
      run_random(150);

      // full rate both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_limit(0);
      send_text("12");             // zero limit ignores everything
      send_text("-");
      run_random(30);
      write_limit($urandom_range(3, 16));
      run_random(150);
      write_limit($urandom_range(17, 254));
      run_random(130);

      req_tvalid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("hex_text_to_bytes regression: pass");
      end else begin
         $display("hex_text_to_bytes regression: fail");
      end
      $finish;
   end

endmodule
